FILE: rtl/bmsi_pkg.sv
// Shared types and constants for the bank mapper with scanline IRQ.
// Used by bmsi_map, bmsi_state and bank_mapper_with_scanline_irq.
package bmsi_pkg;

	// event kinds
	localparam logic [2:0] KIND_CPU_READ  = 3'd0;
	localparam logic [2:0] KIND_CPU_WRITE = 3'd1;
	localparam logic [2:0] KIND_PPU       = 3'd2;
	localparam logic [2:0] KIND_TICK      = 3'd3;
	localparam logic [2:0] KIND_IRQ_ACK   = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANK_COUNT   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_MIRRORING = 2'd1;

	localparam logic [8:0] PRG_COUNT_RESET  = 9'd2;
	localparam logic [8:0] PRG_COUNT_SMALL  = 9'd64;

	// mirroring codes
	localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
	localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
	localparam logic [1:0] MIRROR_FOUR       = 2'd2;

	// CPU 8 kB windows in 0x8000-0xFFFF
	localparam logic [1:0] WIN_0 = 2'd0;
	localparam logic [1:0] WIN_1 = 2'd1;
	localparam logic [1:0] WIN_2 = 2'd2;
	localparam logic [1:0] WIN_3 = 2'd3;

	// bank register numbers
	localparam logic [2:0] BANK_R1 = 3'd1;
	localparam logic [2:0] BANK_R6 = 3'd6;
	localparam logic [2:0] BANK_R7 = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] address;
		logic [7:0]  data;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [21:0] mapped_address;
		logic        irq;
		logic [1:0]  mirroring;
		logic        prg_ram_enabled;
	} rsp_t;

	// state the address mapping needs
	typedef struct packed {
		logic [7:0][7:0] banks;
		logic            prg_mode;
		logic            chr_mode;
	} map_state_t;

	// flags after the current transaction
	typedef struct packed {
		logic       irq;
		logic [1:0] mirroring;
		logic       ram_enable;
	} status_t;

endpackage

FILE: rtl/bank_mapper_with_scanline_irq.sv
// Cartridge bank mapper with scanline IRQ counter. Takes one event per transaction
// (CPU read/write, PPU access, scanline tick, IRQ acknowledge) and returns one
// result: ROM offset and hit for reads, plus IRQ line, mirroring and RAM enable
// as they stand after the event. One transaction is taken per clock while the
// result side is not stalled by rsp_ready. Each passes the input register, then the
// decode, bank lookup and register update, then the result register. The result
// register decouples the sides, so a new transaction is taken while a result waits.
// Configuration writes are accepted at any time but must only be issued while
// idle. Depends on bmsi_pkg, bmsi_map and bmsi_state.
module bank_mapper_with_scanline_irq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  bmsi_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output bmsi_pkg::rsp_t                   rsp,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bmsi_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [8:0]                       cfg_value
);
	import bmsi_pkg::*;

	req_t       req_s1;
	logic       req_valid_s1;
	logic       advance;
	logic       rsp_valid_q;
	rsp_t       rsp_q;
	logic [8:0] prg_count_q;
	logic [1:0] header_mirr_q;
	map_state_t map_st;
	status_t    status;
	logic       hit;
	logic [21:0] mapped;

	assign advance   = req_valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !req_valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q   <= PRG_COUNT_RESET;
			header_mirr_q <= MIRROR_VERTICAL;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PRG_BANK_COUNT:   prg_count_q   <= cfg_value;
				CFG_HEADER_MIRRORING: header_mirr_q <= cfg_value[1:0];
				default:              prg_count_q   <= prg_count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			req_valid_s1 <= 1'b0;
		else if (req_ready)
			req_valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			req_s1 <= req;
	end

	bmsi_map u_map (
		.item           (req_s1),
		.st             (map_st),
		.prg_bank_count (prg_count_q),
		.hit            (hit),
		.mapped_address (mapped)
	);

	bmsi_state u_state (
		.clk              (clk),
		.arst_n           (arst_n),
		.update           (advance),
		.item             (req_s1),
		.prg_bank_count   (prg_count_q),
		.header_mirroring (header_mirr_q),
		.map_st           (map_st),
		.status           (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (advance)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.hit             <= hit;
			rsp_q.mapped_address  <= mapped;
			rsp_q.irq             <= status.irq;
			rsp_q.mirroring       <= status.mirroring;
			rsp_q.prg_ram_enabled <= status.ram_enable;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// an acknowledge always leaves the IRQ line low
	a_ack_clears_irq: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.kind == KIND_IRQ_ACK |=> !rsp_q.irq)
		else $error("irq still set after acknowledge");

	// writes and ticks never report a ROM hit
	a_no_hit_on_events: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (req_s1.kind == KIND_CPU_WRITE || req_s1.kind == KIND_TICK)
		|=> !rsp_q.hit && rsp_q.mapped_address == '0)
		else $error("hit reported for non-read event");

	// four-screen header locks mirroring
	a_four_screen: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && header_mirr_q[1] |-> rsp_q.mirroring == MIRROR_FOUR)
		else $error("mirroring not locked to four screen");

endmodule

FILE: rtl/bmsi_map.sv
// Address translation: CPU 8 kB windows to PRG offsets, PPU 1/2 kB windows
// to CHR offsets. Depends on bmsi_pkg.
module bmsi_map (
	input  bmsi_pkg::req_t       item,
	input  bmsi_pkg::map_state_t st,
	input  logic [8:0]           prg_bank_count,
	output logic                 hit,
	output logic [21:0]          mapped_address
);
	import bmsi_pkg::*;

	logic [8:0]  dbl_count;
	logic [8:0]  second_last;
	logic [8:0]  last;
	logic [8:0]  prg_bank;
	logic [21:0] prg_addr;
	logic [21:0] chr_addr;
	logic        two_kb;
	logic [7:0]  chr_bank;

	assign dbl_count   = {prg_bank_count[7:0], 1'b0};
	assign second_last = dbl_count - 9'd2;
	assign last        = dbl_count - 9'd1;

	always_comb begin
		case (item.address[14:13])
			WIN_0:   prg_bank = st.prg_mode ? second_last : {1'b0, st.banks[BANK_R6]};
			WIN_1:   prg_bank = {1'b0, st.banks[BANK_R7]};
			WIN_2:   prg_bank = st.prg_mode ? {1'b0, st.banks[BANK_R6]} : second_last;
			default: prg_bank = last;
		endcase
	end

	assign prg_addr = {prg_bank, item.address[12:0]};

	// low pattern table is 2 kB banked unless chr_mode swaps the halves
	assign two_kb = (!item.address[12]) != st.chr_mode;

	always_comb begin
		if (two_kb) begin
			chr_bank = st.banks[{2'b00, item.address[11]}];
			chr_addr = {4'd0, chr_bank, 10'd0} + {11'd0, item.address[10:0]};
		end else begin
			chr_bank = st.banks[3'd2 + {1'b0, item.address[11:10]}];
			chr_addr = {4'd0, chr_bank, item.address[9:0]};
		end
	end

	always_comb begin
		hit            = 1'b0;
		mapped_address = '0;
		case (item.kind)
			KIND_CPU_READ: begin
				if (item.address[15]) begin
					hit            = 1'b1;
					mapped_address = prg_addr;
				end
			end
			KIND_PPU: begin
				if (item.address[15:13] == 3'd0) begin
					hit            = 1'b1;
					mapped_address = chr_addr;
				end
			end
			default: begin
				hit            = 1'b0;
				mapped_address = '0;
			end
		endcase
	end

endmodule

FILE: rtl/bmsi_state.sv
// Mapper register file and IRQ counter, updated once per processed transaction.
// Depends on bmsi_pkg.
module bmsi_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 update,
	input  bmsi_pkg::req_t       item,
	input  logic [8:0]           prg_bank_count,
	input  logic [1:0]           header_mirroring,
	output bmsi_pkg::map_state_t map_st,
	output bmsi_pkg::status_t    status
);
	import bmsi_pkg::*;

	logic [7:0][7:0] banks_q,    banks_d;
	logic [2:0]      bank_sel_q, bank_sel_d;
	logic            prg_mode_q, prg_mode_d;
	logic            chr_mode_q, chr_mode_d;
	logic            ram_en_q,   ram_en_d;
	logic            mirror_q,   mirror_d;
	logic            mirror_wr_q, mirror_wr_d;
	logic [7:0]      counter_q,  counter_d;
	logic [7:0]      latch_q,    latch_d;
	logic            reload_q,   reload_d;
	logic            irq_en_q,   irq_en_d;
	logic            pending_q,  pending_d;
	logic [7:0]      bank_val;
	logic            odd;

	assign odd = item.address[0];

	always_comb begin
		bank_val = item.data;
		if (bank_sel_q >= BANK_R6 && prg_bank_count <= PRG_COUNT_SMALL)
			bank_val = item.data & 8'h3F;
		else if (bank_sel_q <= BANK_R1)
			bank_val = item.data & 8'hFE;
	end

	always_comb begin
		banks_d     = banks_q;
		bank_sel_d  = bank_sel_q;
		prg_mode_d  = prg_mode_q;
		chr_mode_d  = chr_mode_q;
		ram_en_d    = ram_en_q;
		mirror_d    = mirror_q;
		mirror_wr_d = mirror_wr_q;
		counter_d   = counter_q;
		latch_d     = latch_q;
		reload_d    = reload_q;
		irq_en_d    = irq_en_q;
		pending_d   = pending_q;
		case (item.kind)
			KIND_CPU_WRITE: begin
				if (item.address[15]) begin
					case (item.address[14:13])
						WIN_0: begin
							if (odd) begin
								banks_d[bank_sel_q] = bank_val;
							end else begin
								bank_sel_d = item.data[2:0];
								prg_mode_d = item.data[6];
								chr_mode_d = item.data[7];
							end
						end
						WIN_1: begin
							if (odd) begin
								ram_en_d = item.data[7];
							end else if (!header_mirroring[1]) begin
								mirror_d    = item.data[0];
								mirror_wr_d = 1'b1;
							end
						end
						WIN_2: begin
							if (odd)
								reload_d = 1'b1;
							else
								latch_d = item.data;
						end
						default: begin
							irq_en_d = odd;
							if (!odd)
								pending_d = 1'b0;
						end
					endcase
				end
			end
			KIND_TICK: begin
				if (counter_q == 8'd0 || reload_q) begin
					counter_d = latch_q;
					reload_d  = 1'b0;
				end else begin
					counter_d = counter_q - 8'd1;
				end
				if (counter_d == 8'd0 && irq_en_q)
					pending_d = 1'b1;
			end
			KIND_IRQ_ACK: begin
				pending_d = 1'b0;
			end
			default: begin
				pending_d = pending_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			banks_q     <= '0;
			bank_sel_q  <= '0;
			prg_mode_q  <= 1'b0;
			chr_mode_q  <= 1'b0;
			ram_en_q    <= 1'b1;
			mirror_q    <= 1'b0;
			mirror_wr_q <= 1'b0;
			counter_q   <= '0;
			latch_q     <= '0;
			reload_q    <= 1'b0;
			irq_en_q    <= 1'b0;
			pending_q   <= 1'b0;
		end else if (update) begin
			banks_q     <= banks_d;
			bank_sel_q  <= bank_sel_d;
			prg_mode_q  <= prg_mode_d;
			chr_mode_q  <= chr_mode_d;
			ram_en_q    <= ram_en_d;
			mirror_q    <= mirror_d;
			mirror_wr_q <= mirror_wr_d;
			counter_q   <= counter_d;
			latch_q     <= latch_d;
			reload_q    <= reload_d;
			irq_en_q    <= irq_en_d;
			pending_q   <= pending_d;
		end
	end

	assign map_st.banks    = banks_q;
	assign map_st.prg_mode = prg_mode_q;
	assign map_st.chr_mode = chr_mode_q;

	// header value 2 or 3 locks four-screen mirroring
	always_comb begin
		status.irq        = pending_d;
		status.ram_enable = ram_en_d;
		if (header_mirroring[1])
			status.mirroring = MIRROR_FOUR;
		else if (mirror_wr_d)
			status.mirroring = mirror_d ? MIRROR_HORIZONTAL : MIRROR_VERTICAL;
		else
			status.mirroring = header_mirroring;
	end

endmodule
